>>> hw/rtl/vie_pkg.sv
// ----------------------------------------------------------------------------
// vie_pkg
// Shared types and constants for the instruction executor: item modes,
// opcodes and the memory request bundles.
// ----------------------------------------------------------------------------
package vie_pkg;

   localparam int MemBytesDefault = 256;
   localparam int NumRegsDefault  = 16;
   localparam logic [7:0] StartAddressReset = 8'd10;

   // item modes
   localparam logic [1:0] MODE_MEM_WRITE = 2'd0;
   localparam logic [1:0] MODE_MEM_READ  = 2'd1;
   localparam logic [1:0] MODE_REG_READ  = 2'd2;
   localparam logic [1:0] MODE_EXECUTE   = 2'd3;

   // opcodes (top nibble of the instruction)
   localparam logic [3:0] OP_LOAD  = 4'h1;
   localparam logic [3:0] OP_IMM   = 4'h2;
   localparam logic [3:0] OP_STORE = 4'h3;
   localparam logic [3:0] OP_MOVE  = 4'h4;
   localparam logic [3:0] OP_ADD   = 4'h5;
   localparam logic [3:0] OP_FADD  = 4'h6;
   localparam logic [3:0] OP_OR    = 4'h7;
   localparam logic [3:0] OP_AND   = 4'h8;
   localparam logic [3:0] OP_XOR   = 4'h9;
   localparam logic [3:0] OP_ROT   = 4'hA;
   localparam logic [3:0] OP_JEQ   = 4'hB;
   localparam logic [3:0] OP_HALT  = 4'hC;
   localparam logic [3:0] OP_JGT   = 4'hD;
   localparam logic [3:0] OP_NONE  = 4'h0;

   // one access to main memory (write and read share an address)
   typedef struct packed {
      logic       we;
      logic [7:0] addr;
      logic [7:0] wdata;
   } mem_req_type;

   // one access to the register file
   typedef struct packed {
      logic       we;
      logic [3:0] waddr;
      logic [7:0] wdata;
      logic [3:0] raddr;
   } rf_req_type;

endpackage

>>> hw/rtl/vie_ram.sv
// ----------------------------------------------------------------------------
// vie_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module vie_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/vie_fadd.sv
// ----------------------------------------------------------------------------
// vie_fadd
// Eight-bit float add: sign, excess-4 exponent, 4-bit mantissa. Truncates,
// normalizes and saturates at 7.5.
// ----------------------------------------------------------------------------
module vie_fadd
   import vie_pkg::*;
(
   input  logic [7:0] a,
   input  logic [7:0] b,
   output logic [7:0] sum
);

   logic signed [12:0] va;
   logic signed [12:0] vb;
   logic signed [12:0] total;
   logic [11:0]        mag;
   logic [3:0]         msb;
   logic [3:0]         expo;
   logic [11:0]        shifted;

   // expand operands to fixed point in units of 1/256
   always_comb begin
      va = $signed({2'b00, 11'(a[3:0]) << a[6:4]});
      vb = $signed({2'b00, 11'(b[3:0]) << b[6:4]});
      if (a[7]) va = -va;
      if (b[7]) vb = -vb;
      total = va + vb;
      mag   = total[12] ? 12'(-total) : total[11:0];
   end

   // find the leading one and re-encode
   always_comb begin
      msb = 4'd0;
      for (int i = 0; i < 12; i++) begin
         if (mag[i]) msb = 4'(i);
      end
      expo    = (msb >= 4'd3) ? msb - 4'd3 : 4'd0;
      shifted = mag >> expo;
      if (mag == 12'd0) begin
         sum = 8'h00;
      end else if (expo > 4'd7) begin
         sum = {total[12], 7'h7F};
      end else begin
         sum = {total[12], expo[2:0], shifted[3:0]};
      end
   end

endmodule

>>> hw/rtl/vie_exec.sv
// ----------------------------------------------------------------------------
// vie_exec
// Sequencer: clears main memory after reset, then runs each item as reads and
// at most one write back against main memory and the register file.
// ----------------------------------------------------------------------------
module vie_exec
   import vie_pkg::*;
#(
   parameter int MEM_BYTES = MemBytesDefault,
   parameter int NUM_REGS  = NumRegsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_address,
   input  logic [7:0]  req_write_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_value,
   output logic [7:0]  rsp_pc_after,
   output logic        rsp_halted,
   output logic        rsp_screen_valid,
   output logic [3:0]  rsp_executed_opcode,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   output mem_req_type mem_req,
   input  logic [7:0]  mem_rdata,
   output rf_req_type  rf_req,
   input  logic [7:0]  rf_rdata
);

   localparam int AddrW = $clog2(MEM_BYTES);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_MRD, S_RRD, S_F1, S_F2,
      S_X1, S_X2, S_X3, S_X4, S_RESP
   } state_type;

   state_type          state_ff;
   logic [AddrW-1:0]   clr_ff;
   logic [7:0]         pc_ff;
   logic               halt_ff;
   logic [NUM_REGS-1:0] rf_valid_ff;
   logic               rf_ok_ff;
   logic [7:0]         hi_ff, lo_ff, md_ff, ra_ff, rb_ff, rc_ff;
   logic [7:0]         pend_rd_ff;
   logic               pend_scr_ff;
   logic [3:0]         pend_opc_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_rd_ff, rsp_pc_ff;
   logic               rsp_halt_ff, rsp_scr_ff;
   logic [3:0]         rsp_opc_ff;

   logic [7:0] rf_val, fsum, rot, pc_in;
   logic [3:0] n1, n2, n3, n4;
   logic       halt_in, scr_in;
   logic       rsp_load;

   assign n1 = hi_ff[7:4];
   assign n2 = hi_ff[3:0];
   assign n3 = lo_ff[7:4];
   assign n4 = lo_ff[3:0];

   // registers never written read as zero
   assign rf_val = rf_ok_ff ? rf_rdata : 8'h00;
   assign rot    = 8'({ra_ff, ra_ff} >> n4[2:0]);

   vie_fadd u_fadd (.a(rb_ff), .b(rc_ff), .sum(fsum));

   assign req_ready = (state_ff == S_IDLE);

   // load the result register once the previous beat has left
   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   // drive memory and register file accesses, decode the execute step
   always_comb begin
      mem_req = '0;
      rf_req  = '0;
      pc_in   = pc_ff;
      halt_in = halt_ff;
      scr_in  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            mem_req.we   = 1'b1;
            mem_req.addr = 8'(clr_ff);
         end
         S_IDLE: begin
            if (req_mode == MODE_MEM_WRITE) begin
               mem_req.we    = req_valid;
               mem_req.addr  = req_address;
               mem_req.wdata = req_write_value;
            end else if (req_mode == MODE_EXECUTE) begin
               mem_req.addr = pc_ff;
            end else begin
               mem_req.addr = req_address;
            end
            rf_req.raddr = req_address[3:0];
         end
         S_F1: mem_req.addr = pc_ff + 8'd1;
         S_F2: begin
            mem_req.addr = mem_rdata;
            rf_req.raddr = n2;
         end
         S_X1: rf_req.raddr = n3;
         S_X2: rf_req.raddr = n4;
         S_X3: rf_req.raddr = 4'd0;
         S_X4: begin
            rf_req.waddr = n2;
            case (n1)
               OP_LOAD: begin
                  rf_req.we = 1'b1; rf_req.wdata = md_ff;
               end
               OP_IMM: begin
                  rf_req.we = 1'b1; rf_req.wdata = lo_ff;
               end
               OP_STORE: begin
                  mem_req.we = 1'b1; mem_req.addr = lo_ff; mem_req.wdata = ra_ff;
                  scr_in = (lo_ff == 8'h00);
               end
               OP_MOVE: begin
                  rf_req.we = (n2 == 4'd0); rf_req.waddr = n4; rf_req.wdata = rb_ff;
               end
               OP_ADD: begin
                  rf_req.we = 1'b1; rf_req.wdata = rb_ff + rc_ff;
               end
               OP_FADD: begin
                  rf_req.we = 1'b1; rf_req.wdata = fsum;
               end
               OP_OR: begin
                  rf_req.we = 1'b1; rf_req.wdata = rb_ff | rc_ff;
               end
               OP_AND: begin
                  rf_req.we = 1'b1; rf_req.wdata = rb_ff & rc_ff;
               end
               OP_XOR: begin
                  rf_req.we = 1'b1; rf_req.wdata = rb_ff ^ rc_ff;
               end
               OP_ROT: begin
                  rf_req.we = (n3 == 4'd0); rf_req.wdata = rot;
               end
               OP_JEQ: if (ra_ff == rf_val) pc_in = lo_ff;
               OP_HALT: if (n2 == 4'd0 && lo_ff == 8'h00) halt_in = 1'b1;
               OP_JGT: if ($signed(ra_ff) > $signed(rf_val)) pc_in = lo_ff;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // hold state, architectural registers and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= StartAddressReset;
         halt_ff      <= 1'b0;
         rf_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rf_ok_ff <= rf_valid_ff[rf_req.raddr];
         if (rf_req.we) rf_valid_ff[rf_req.waddr] <= 1'b1;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            pc_ff <= csr_write_data;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AddrW'(MEM_BYTES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               pend_rd_ff  <= 8'h00;
               pend_scr_ff <= 1'b0;
               pend_opc_ff <= OP_NONE;
               if (req_valid) begin
                  case (req_mode)
                     MODE_MEM_READ: state_ff <= S_MRD;
                     MODE_REG_READ: state_ff <= S_RRD;
                     MODE_EXECUTE:  state_ff <= halt_ff ? S_RESP : S_F1;
                     default:       state_ff <= S_RESP;
                  endcase
               end
            end
            S_MRD: begin
               pend_rd_ff <= mem_rdata;
               state_ff   <= S_RESP;
            end
            S_RRD: begin
               pend_rd_ff <= rf_val;
               state_ff   <= S_RESP;
            end
            S_F1: begin
               hi_ff    <= mem_rdata;
               state_ff <= S_F2;
            end
            S_F2: begin
               lo_ff    <= mem_rdata;
               pc_ff    <= pc_ff + 8'd2;
               state_ff <= S_X1;
            end
            S_X1: begin
               md_ff    <= mem_rdata;
               ra_ff    <= rf_val;
               state_ff <= S_X2;
            end
            S_X2: begin
               rb_ff    <= rf_val;
               state_ff <= S_X3;
            end
            S_X3: begin
               rc_ff    <= rf_val;
               state_ff <= S_X4;
            end
            S_X4: begin
               pc_ff       <= pc_in;
               halt_ff     <= halt_in;
               pend_scr_ff <= scr_in;
               pend_opc_ff <= n1;
               state_ff    <= S_RESP;
            end
            S_RESP: begin
               if (rsp_load) begin
                  rsp_rd_ff    <= pend_rd_ff;
                  rsp_pc_ff    <= pc_ff;
                  rsp_halt_ff  <= halt_ff;
                  rsp_scr_ff   <= pend_scr_ff;
                  rsp_opc_ff   <= pend_opc_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_value      = rsp_rd_ff;
   assign rsp_pc_after        = rsp_pc_ff;
   assign rsp_halted          = rsp_halt_ff;
   assign rsp_screen_valid    = rsp_scr_ff;
   assign rsp_executed_opcode = rsp_opc_ff;

   // no item is taken while memory is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready) else $error("accept during clear");

   // halt is sticky until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(halt_ff) && !$past(reset) |-> halt_ff) else $error("halt dropped");

   // one write back per step, never to both stores
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.we && rf_req.we)) else $error("double write");

   // screen beat only comes from a store
   a_screen_store: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_screen_valid |-> rsp_executed_opcode == OP_STORE)
      else $error("screen without store");

endmodule

>>> hw/rtl/vole_instruction_executor.sv
// ----------------------------------------------------------------------------
// vole_instruction_executor
// Eight-bit stored-program CPU with 16 registers and a 256-byte memory.
// ----------------------------------------------------------------------------
// After reset the block clears all MEM_BYTES bytes of main memory before it
// raises req_ready. Items are handled one at a time by a sequencer around
// two synchronous RAMs, each with one write and one read port. A halted
// execute item goes straight to its result; an executed instruction runs
// two instruction fetches, three register operand reads plus register 0,
// then at most one write back, in that order, as each RAM has one read
// port. The next item is taken while a result still waits.
module vole_instruction_executor
   import vie_pkg::*;
#(
   parameter int MEM_BYTES = MemBytesDefault,
   parameter int NUM_REGS  = NumRegsDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_address,
   input  logic [7:0] req_write_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_value,
   output logic [7:0] rsp_pc_after,
   output logic       rsp_halted,
   output logic       rsp_screen_valid,
   output logic [3:0] rsp_executed_opcode,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   localparam int AddrW = $clog2(MEM_BYTES);
   localparam int RegW  = $clog2(NUM_REGS);

   mem_req_type mem_req;
   rf_req_type  rf_req;
   logic [7:0]  mem_rdata;
   logic [7:0]  rf_rdata;

   // sequencer
   vie_exec #(.MEM_BYTES(MEM_BYTES), .NUM_REGS(NUM_REGS)) u_exec (
      .clock, .reset,
      .req_valid, .req_ready, .req_mode, .req_address, .req_write_value,
      .rsp_valid, .rsp_ready, .rsp_read_value, .rsp_pc_after, .rsp_halted,
      .rsp_screen_valid, .rsp_executed_opcode,
      .csr_write_enable, .csr_write_data,
      .mem_req, .mem_rdata, .rf_req, .rf_rdata
   );

   // main memory
   vie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_main_mem (
      .clock,
      .we    (mem_req.we),
      .waddr (AddrW'(mem_req.addr)),
      .wdata (mem_req.wdata),
      .raddr (AddrW'(mem_req.addr)),
      .rdata (mem_rdata)
   );

   // register file
   vie_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_reg_file (
      .clock,
      .we    (rf_req.we),
      .waddr (RegW'(rf_req.waddr)),
      .wdata (rf_req.wdata),
      .raddr (RegW'(rf_req.raddr)),
      .rdata (rf_rdata)
   );

endmodule

>>> sim/tb_vole_instruction_executor.sv
// ----------------------------------------------------------------------------
// tb_vole_instruction_executor
// Self-checking bench for the instruction executor. A scoreboard class keeps
// its own copy of registers, memory, program counter and halt flag, predicts
// the response of every accepted request beat, and checks each response beat
// in order. Stimulus loads short random programs at varied start addresses,
// runs them with reads and noise mixed in, and ends with the halt sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_vole_instruction_executor;
   import vie_pkg::*;

   typedef struct packed {
      logic [7:0] read_value;
      logic [7:0] pc_after;
      logic       halted;
      logic       screen_valid;
      logic [3:0] executed_opcode;
   } vole_result_t;

   // Tracks machine state and the queue of responses still owed.
   class vole_scoreboard;
      logic [7:0]   regs[16];
      logic [7:0]   mem[256];
      logic [7:0]   pc;
      logic [7:0]   start_pc;
      bit           halt;
      vole_result_t owed_q[$];
      int           errors;

      function new();
         foreach (regs[i]) regs[i] = '0;
         foreach (mem[i]) mem[i] = '0;
         start_pc = StartAddressReset;
         pc       = StartAddressReset;
         halt     = 0;
         errors   = 0;
      endfunction

      function void load_start(logic [7:0] v);
         start_pc = v;
         pc       = v;
      endfunction

      // Signed value of a float byte in units of 2^-8.
      function int float_units(logic [7:0] v);
         int mag;
         mag = int'(v[3:0]) << v[6:4];
         return v[7] ? -mag : mag;
      endfunction

      function logic [7:0] float_sum(logic [7:0] x, logic [7:0] y);
         int         total;
         int         mag;
         int         e;
         logic [7:0] sgn;
         total = float_units(x) + float_units(y);
         sgn   = (total < 0) ? 8'h80 : 8'h00;
         mag   = (total < 0) ? -total : total;
         e     = 4;
         if (mag == 0) return 8'h00;
         if (mag >= 256) begin
            while (e < 8 && mag >= (1 << (e + 4))) e++;
            if (e > 7) return sgn | 8'h7F;
         end else begin
            while (e > 0 && mag < (1 << (e + 3))) e--;
         end
         return sgn | 8'(e << 4) | 8'((mag >> e) & 15);
      endfunction

      // Advance the state by one accepted request beat.
      function void note(logic [1:0] mode, logic [7:0] addr, logic [7:0] wval);
         vole_result_t r;
         logic [7:0]   hi, lo;
         logic [3:0]   n1, n2, n3, n4;
         logic [15:0]  dbl;
         r = '0;
         if (mode == MODE_MEM_WRITE) begin
            mem[addr] = wval;
         end else if (mode == MODE_MEM_READ) begin
            r.read_value = mem[addr];
         end else if (mode == MODE_REG_READ) begin
            r.read_value = regs[addr[3:0]];
         end else if (!halt) begin
            hi = mem[pc];
            lo = mem[8'(pc + 8'd1)];
            {n1, n2} = hi;
            {n3, n4} = lo;
            pc = 8'(pc + 8'd2);
            r.executed_opcode = n1;
            case (n1)
               OP_LOAD:  regs[n2] = mem[lo];
               OP_IMM:   regs[n2] = lo;
               OP_STORE: begin
                  mem[lo] = regs[n2];
                  r.screen_valid = (lo == 8'h00);
               end
               OP_MOVE:  if (n2 == 0) regs[n4] = regs[n3];
               OP_ADD:   regs[n2] = 8'(regs[n3] + regs[n4]);
               OP_FADD:  regs[n2] = float_sum(regs[n3], regs[n4]);
               OP_OR:    regs[n2] = regs[n3] | regs[n4];
               OP_AND:   regs[n2] = regs[n3] & regs[n4];
               OP_XOR:   regs[n2] = regs[n3] ^ regs[n4];
               OP_ROT: begin
                  if (n3 == 0) begin
                     dbl = {regs[n2], regs[n2]} >> n4[2:0];
                     regs[n2] = dbl[7:0];
                  end
               end
               OP_JEQ:   if (regs[n2] == regs[0]) pc = lo;
               OP_HALT:  if (n2 == 0 && lo == 0) halt = 1;
               OP_JGT:   if ($signed(regs[n2]) > $signed(regs[0])) pc = lo;
               default: ;
            endcase
         end
         r.pc_after = pc;
         r.halted   = halt;
         owed_q.push_back(r);
      endfunction

      function void field_check(string name, int want, int got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      // Compare one response beat with the oldest owed result.
      function void check(vole_result_t got);
         vole_result_t want;
         if (owed_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: expected none, actual %h", $time, got);
            return;
         end
         want = owed_q.pop_front();
         field_check("read_value", want.read_value, got.read_value);
         field_check("pc_after", want.pc_after, got.pc_after);
         field_check("halted", want.halted, got.halted);
         field_check("screen_valid", want.screen_valid, got.screen_valid);
         field_check("executed_opcode", want.executed_opcode, got.executed_opcode);
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   logic [1:0] req_mode = '0;
   logic [7:0] req_address = '0;
   logic [7:0] req_write_value = '0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic [7:0] rsp_read_value;
   logic [7:0] rsp_pc_after;
   logic       rsp_halted;
   logic       rsp_screen_valid;
   logic [3:0] rsp_executed_opcode;
   logic       csr_write_enable = 0;
   logic [7:0] csr_write_data = '0;

   vole_scoreboard sb = new();
   bit calm = 0;
   int beats_sent = 0;

   vole_instruction_executor u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_address        (req_address),
      .req_write_value    (req_write_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_read_value     (rsp_read_value),
      .rsp_pc_after       (rsp_pc_after),
      .rsp_halted         (rsp_halted),
      .rsp_screen_valid   (rsp_screen_valid),
      .rsp_executed_opcode(rsp_executed_opcode),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Check every response beat at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check({rsp_read_value, rsp_pc_after, rsp_halted, rsp_screen_valid,
                   rsp_executed_opcode});
   end

   // Stall the response side in random bursts until the calm tail.
   initial begin
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready = 0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_ready = 1;
         end else begin
            rsp_ready = 1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   // Send one request beat; hold it until accepted, then note it.
   task automatic send(logic [1:0] mode, logic [7:0] addr, logic [7:0] wval);
      if (!calm && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_valid = 0;
         repeat ($urandom_range(1, 8) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       = 1;
      req_mode        = mode;
      req_address     = addr;
      req_write_value = wval;
      do @(posedge clock); while (!req_ready);
      sb.note(mode, addr, wval);
      beats_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Drain, then write the start address while the block is idle.
   task automatic set_start(logic [7:0] v);
      drain();
      @(negedge clock);
      csr_write_enable = 1;
      csr_write_data   = v;
      @(negedge clock);
      csr_write_enable = 0;
      sb.load_start(v);
   endtask

   // Step, but first break an accidental halt word at the PC.
   task automatic step_safe();
      if (sb.mem[sb.pc] == 8'hC0 && sb.mem[8'(sb.pc + 8'd1)] == 8'h00)
         send(MODE_MEM_WRITE, 8'(sb.pc + 8'd1), 8'(($urandom_range(1, 255))));
      send(MODE_EXECUTE, $urandom, $urandom);
   endtask

   // Random instruction word, never the halt word.
   function automatic logic [15:0] random_instr(logic [7:0] base, int len);
      logic [3:0] op;
      logic [7:0] lo;
      logic [3:0] r;
      op = 4'($urandom_range(0, 15));
      r  = 4'($urandom);
      lo = 8'($urandom);
      case (op)
         OP_MOVE: if ($urandom_range(0, 4) != 0) r = 4'h0;
         OP_ROT:  if ($urandom_range(0, 4) != 0) lo[7:4] = 4'h0;
         OP_JEQ, OP_JGT:
            if ($urandom_range(0, 3) != 0)
               lo = 8'(base + 2 * $urandom_range(0, len - 1));
         OP_STORE: if ($urandom_range(0, 5) == 0) lo = 8'h00;
         OP_HALT:  if (r == 0 && lo == 0) lo = 8'h01;
         default: ;
      endcase
      return {op, r, lo};
   endfunction

   logic [15:0] directed_prog[] = '{
      16'h21FF, 16'h2280, 16'h5312, 16'h6412, 16'h257F, 16'h267F, 16'h6756,
      16'h7712, 16'h8812, 16'h9912, 16'hA103, 16'hA110, 16'h4012, 16'h4112,
      16'h3100, 16'h1800, 16'hB10C, 16'hD12A, 16'hE000, 16'hC012
   };

   initial begin
      logic [7:0]  base;
      logic [15:0] w;
      int          len;
      int          phase;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed program at the reset start address.
      foreach (directed_prog[i]) begin
         send(MODE_MEM_WRITE, 8'(StartAddressReset + 2 * i), directed_prog[i][15:8]);
         send(MODE_MEM_WRITE, 8'(StartAddressReset + 2 * i + 1), directed_prog[i][7:0]);
      end
      repeat (directed_prog.size()) step_safe();
      send(MODE_MEM_READ, 8'hFF, 8'h00);
      send(MODE_MEM_READ, 8'h00, 8'hFF);
      send(MODE_REG_READ, 8'hF7, 8'h00);
      for (int i = 0; i < 16; i++) send(MODE_REG_READ, 8'(i), $urandom);

      // Random programs at varied start addresses.
      phase = 0;
      while (beats_sent < 1450) begin
         case (phase)
            0:       base = 8'hFF;
            1:       base = 8'h00;
            2:       base = 8'hFE;
            default: base = 8'($urandom);
         endcase
         set_start(base);
         len = $urandom_range(3, 12);
         for (int i = 0; i < len; i++) begin
            w = random_instr(base, len);
            send(MODE_MEM_WRITE, 8'(base + 2 * i), w[15:8]);
            send(MODE_MEM_WRITE, 8'(base + 2 * i + 1), w[7:0]);
         end
         repeat ($urandom_range(0, 4)) send(MODE_MEM_WRITE, $urandom, $urandom);
         repeat ($urandom_range(len, 3 * len)) begin
            case ($urandom_range(0, 9))
               0:       send(MODE_MEM_READ, $urandom, $urandom);
               1:       send(MODE_REG_READ, $urandom, $urandom);
               2:       send(MODE_MEM_WRITE, $urandom, $urandom);
               default: step_safe();
            endcase
         end
         phase++;
      end

      // Calm tail: halt, then confirm later steps change nothing and other modes still work.
      calm = 1;
      set_start(8'h80);
      send(MODE_MEM_WRITE, 8'h80, 8'h2A);
      send(MODE_MEM_WRITE, 8'h81, 8'h5C);
      send(MODE_MEM_WRITE, 8'h82, 8'hC0);
      send(MODE_MEM_WRITE, 8'h83, 8'h00);
      send(MODE_EXECUTE, 8'h00, 8'h00);
      send(MODE_EXECUTE, 8'hFF, 8'hFF);
      send(MODE_EXECUTE, 8'h00, 8'h00);
      send(MODE_MEM_WRITE, 8'h55, 8'hAA);
      send(MODE_MEM_READ, 8'h55, 8'h00);
      send(MODE_REG_READ, 8'h0A, 8'h00);
      repeat (40) begin
         case ($urandom_range(0, 3))
            0:       send(MODE_MEM_WRITE, $urandom, $urandom);
            1:       send(MODE_MEM_READ, $urandom, $urandom);
            2:       send(MODE_REG_READ, $urandom, $urandom);
            default: send(MODE_EXECUTE, $urandom, $urandom);
         endcase
      end
      drain();

      if (sb.errors == 0)
         $display("tb_vole_instruction_executor OK");
      else
         $display("tb_vole_instruction_executor NOT OK");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #3ms;
      $display("tb_vole_instruction_executor NOT OK");
      $finish;
   end

endmodule

>>> vole_instruction_executor.f
hw/rtl/vie_pkg.sv
hw/rtl/vie_ram.sv
hw/rtl/vie_fadd.sv
hw/rtl/vie_exec.sv
hw/rtl/vole_instruction_executor.sv
sim/tb_vole_instruction_executor.sv
